[sv/apsk_pkg.sv]
// Shared types, constants and the sine table generator for the ASK/PSK demodulator.
package apsk_pkg;

  // Bit period and carrier setup
  localparam int SAMPLES_PER_BIT = 64;
  localparam longint SAMPLE_RATE = 64000;
  localparam longint CARRIER_FREQ = 4000;

  localparam int POS_W = $clog2(SAMPLES_PER_BIT + 1);
  localparam int IDX_W = $clog2(SAMPLES_PER_BIT);

  localparam int SAMPLE_W = 16;
  localparam int TERM_W = 32;
  localparam int ACC_W = 48;
  localparam int THRESH_W = 40;
  localparam int CFG_IDX_W = 1;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 40'd858993459;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEMOD_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ENERGY_THRESH = 1'b1;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  localparam longint Q30 = 64'sd1 << 30;

  // One classified sample between front and back
  typedef struct packed {
    logic signed [TERM_W-1:0] term;
    logic                     close;
    logic                     last;
    logic                     mode;
  } entry_t;

  // One result item
  typedef struct packed {
    logic       demod_bit;
    logic       byte_valid;
    logic [7:0] byte_value;
    logic       end_of_stream;
  } result_t;

  // sin(pi/2 * y / 16384) as Q1.14, odd polynomial in Q30
  function automatic longint quarter_sine(longint y);
    longint u;
    longint u2;
    longint t;
    longint s;
    u = y * 65536;
    u2 = u * u / Q30;
    t = 172273;
    t = -5026995 + t * u2 / Q30;
    t = 85569306 + t * u2 / Q30;
    t = -693598668 + t * u2 / Q30;
    t = 1686629713 + t * u2 / Q30;
    s = t * u / Q30;
    if (s < 0) s = 0;
    s = (s + 32768) / 65536;
    if (s > 16384) s = 16384;
    return s;
  endfunction

  // Reference entry for sample slot j of a bit period
  function automatic logic signed [SAMPLE_W-1:0] sine_entry(longint j);
    longint x;
    longint ph;
    longint q;
    longint r;
    longint v;
    x = (j * CARRIER_FREQ) % SAMPLE_RATE;
    ph = ((x << 16) + SAMPLE_RATE / 2) / SAMPLE_RATE;
    ph = ph & 64'hFFFF;
    q = (ph >> 14) & 3;
    r = ph & 64'h3FFF;
    v = ((q & 1) != 0) ? quarter_sine(16384 - r) : quarter_sine(r);
    if ((q & 2) != 0) v = -v;
    return v[SAMPLE_W-1:0];
  endfunction

endpackage

[sv/ask_psk_demodulator_bit_packer_unit.sv]
// A sample that closes a bit period is written to the sample queue, then to the result queue, before its result shows.
// Throughput: one sample per cycle while in_full is low; set by the single multiply-accumulate path.
// Results drain one per cycle; full rises only when both small queues back up.
// Reset (synchronous, rst_n low): queues empty, accumulator and packer cleared,
// mode ASK, energy threshold at its default.
module ask_psk_demodulator_bit_packer_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [apsk_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [apsk_pkg::THRESH_W-1:0]        cfg_data,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic signed [apsk_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                 in_last_sample,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output logic                                 out_demod_bit,
  output logic                                 out_byte_valid,
  output logic [7:0]                           out_byte_value,
  output logic                                 out_end_of_stream
);
  import apsk_pkg::*;

  entry_t                fe_entry;
  entry_t                q_entry;
  logic                  q_empty;
  logic                  q_rd;
  logic                  in_take;
  logic [THRESH_W-1:0]   thresh;
  result_t               res;

  assign in_take = in_push && !in_full;

  apsk_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .take        (in_take),
    .sample      (in_sample),
    .last_sample (in_last_sample),
    .entry       (fe_entry),
    .threshold   (thresh)
  );

  apsk_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (in_take),
    .wr_entry (fe_entry),
    .full     (in_full),
    .rd       (q_rd),
    .rd_entry (q_entry),
    .empty    (q_empty)
  );

  apsk_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .entry       (q_entry),
    .entry_empty (q_empty),
    .entry_rd    (q_rd),
    .threshold   (thresh),
    .pop         (out_pop),
    .empty       (out_empty),
    .result      (res)
  );

  assign out_demod_bit     = res.demod_bit;
  assign out_byte_valid    = res.byte_valid;
  assign out_byte_value    = res.byte_value;
  assign out_end_of_stream = res.end_of_stream;

`ifndef SYNTHESIS
  // A last sample always closes its bit period
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && in_last_sample |-> fe_entry.close)
    else $error("last sample did not close the period");

  // No byte value without a completed byte
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_byte_valid |-> out_byte_value == 8'd0)
    else $error("byte value set without byte_valid");

  // Result side starts empty after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> out_empty)
    else $error("result queue not empty after reset");

  // Back end drains only what the queue holds
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_rd |-> !q_empty)
    else $error("back end read an empty queue");
`endif
endmodule

[sv/apsk_front.sv]
// Front end: config registers, period position, sine lookup and per-sample product.
module apsk_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [apsk_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [apsk_pkg::THRESH_W-1:0]   cfg_data,
  input  logic                            take,
  input  logic signed [apsk_pkg::SAMPLE_W-1:0] sample,
  input  logic                            last_sample,
  output apsk_pkg::entry_t                entry,
  output logic [apsk_pkg::THRESH_W-1:0]   threshold
);
  import apsk_pkg::*;

  logic                  mode_r;
  logic [THRESH_W-1:0]   thresh_r;
  logic [POS_W-1:0]      pos_r;
  logic [POS_W-1:0]      pos_nxt;
  logic signed [SAMPLE_W-1:0] rom_w [SAMPLES_PER_BIT];
  logic signed [SAMPLE_W-1:0] ref_val;
  logic signed [SAMPLE_W-1:0] mul_b;
  logic                  close;

  // Build the sine reference table at elaboration
  for (genvar g = 0; g < SAMPLES_PER_BIT; g++) begin : g_rom
    assign rom_w[g] = sine_entry(longint'(g));
  end

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      thresh_r <= THRESH_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_DEMOD_MODE:    mode_r   <= cfg_data[0];
        REG_ENERGY_THRESH: thresh_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Classify: does this sample close the bit period
  assign close   = last_sample || (pos_r == POS_W'(SAMPLES_PER_BIT - 1));
  assign pos_nxt = close ? '0 : pos_r + POS_W'(1);

  // Advance the slot counter on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (take) begin
      pos_r <= pos_nxt;
    end
  end

  // One multiplier: sample times sine in PSK mode, squared in ASK mode
  assign ref_val = rom_w[pos_r[IDX_W-1:0]];
  assign mul_b   = mode_r ? ref_val : sample;

  always_comb begin
    entry.term  = sample * mul_b;
    entry.close = close;
    entry.last  = last_sample;
    entry.mode  = mode_r;
  end

  assign threshold = thresh_r;
endmodule

[sv/apsk_queue.sv]
// Two-entry queue of classified samples between front and back.
module apsk_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr,
  input  apsk_pkg::entry_t wr_entry,
  output logic             full,
  input  logic             rd,
  output apsk_pkg::entry_t rd_entry,
  output logic             empty
);
  import apsk_pkg::*;

  entry_t     mem [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;

  // Write storage
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp_r] <= wr_entry;
    end
  end

  // Track pointers and fill level
  always_comb begin
    cnt_nxt = cnt_r;
    if (wr && !rd) cnt_nxt = cnt_r + 2'd1;
    else if (rd && !wr) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_nxt;
    end
  end

  assign rd_entry = mem[rp_r];
  assign empty    = (cnt_r == 2'd0);
  assign full     = (cnt_r == 2'd2);
endmodule

[sv/apsk_back.sv]
// Back end: saturating accumulate, bit decision, byte packing and result queue.
module apsk_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  apsk_pkg::entry_t              entry,
  input  logic                          entry_empty,
  output logic                          entry_rd,
  input  logic [apsk_pkg::THRESH_W-1:0] threshold,
  input  logic                          pop,
  output logic                          empty,
  output apsk_pkg::result_t             result
);
  import apsk_pkg::*;

  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W:0]   sum_wide;
  logic signed [ACC_W-1:0] sum_sat;
  logic [7:0]              shift_r;
  logic [7:0]              shift_nxt;
  logic [2:0]              bpos_r;
  logic                    dec_bit;
  logic                    close_go;
  result_t                 res;
  result_t                 oq [2];
  logic                    owp_r;
  logic                    orp_r;
  logic [1:0]              ocnt_r;
  logic                    ofull;
  logic                    opop;

  // Take an entry unless it closes a period and the result queue is full
  assign entry_rd = !entry_empty && (!entry.close || !ofull);
  assign close_go = entry_rd && entry.close;

  // Saturating accumulate
  always_comb begin
    sum_wide = {acc_r[ACC_W-1], acc_r} + (ACC_W+1)'(entry.term);
    if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
      sum_sat = sum_wide[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sum_sat = sum_wide[ACC_W-1:0];
    end
  end

  // Decide the bit: PSK on sign, ASK on energy above threshold
  always_comb begin
    if (entry.mode) begin
      dec_bit = sum_sat[ACC_W-1];
    end else begin
      dec_bit = !sum_sat[ACC_W-1] && (sum_sat != '0)
                && (sum_sat[ACC_W-2:0] > (ACC_W-1)'(threshold));
    end
    shift_nxt = {shift_r[6:0], dec_bit};
    res.demod_bit     = dec_bit;
    res.byte_valid    = (bpos_r == 3'd7);
    res.byte_value    = (bpos_r == 3'd7) ? shift_nxt : 8'd0;
    res.end_of_stream = entry.last;
  end

  // Advance accumulator and packer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      shift_r <= '0;
      bpos_r  <= '0;
    end else if (entry_rd) begin
      if (entry.close) begin
        acc_r <= '0;
        if (entry.last) begin
          shift_r <= '0;
          bpos_r  <= '0;
        end else begin
          shift_r <= shift_nxt;
          bpos_r  <= bpos_r + 3'd1;
        end
      end else begin
        acc_r <= sum_sat;
      end
    end
  end

  // Result queue storage
  always_ff @(posedge clk) begin
    if (close_go) begin
      oq[owp_r] <= res;
    end
  end

  assign opop  = pop && !empty;
  assign empty = (ocnt_r == 2'd0);
  assign ofull = (ocnt_r == 2'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= 1'b0;
      orp_r  <= 1'b0;
      ocnt_r <= '0;
    end else begin
      if (close_go) owp_r <= ~owp_r;
      if (opop) orp_r <= ~orp_r;
      if (close_go && !opop) ocnt_r <= ocnt_r + 2'd1;
      else if (opop && !close_go) ocnt_r <= ocnt_r - 2'd1;
    end
  end

  assign result = oq[orp_r];
endmodule
